// File: src/snp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_pkg
// Shared types, codes and saturation helpers of the snapshot table.
// ----------------------------------------------------------------------------
package snp_pkg;

	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_INTERP = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	localparam logic [1:0] MODE_HOLD   = 2'd0;
	localparam logic [1:0] MODE_INTERP = 2'd1;
	localparam logic [1:0] MODE_EXTRAP = 2'd2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 22;
	localparam logic [CFG_IDX_W-1:0] REG_RENDER_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRAP_CAP   = 1'b1;
	localparam logic [19:0] RENDER_DELAY_RST = 20'd100000;
	localparam logic [21:0] EXTRAP_CAP_RST   = 22'd2000000;

	// Angles: 8192 per radian.
	localparam int TWO_PI_Q  = 51472;
	localparam int HALF_WRAP = 25736;
	localparam int HALF_PI_Q = 12868;

	// Restoring divider size.
	localparam int DIV_NW = 58;
	localparam int DIV_DW = 42;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         object_id;
		logic signed [31:0] pos_x_in;
		logic signed [31:0] pos_y_in;
		logic signed [31:0] pos_z_in;
		logic signed [15:0] yaw_in;
		logic signed [15:0] pitch_in;
		logic [39:0]        arrival_time_us;
		logic [19:0]        step_us;
	} snp_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         pose_mode;
		logic signed [31:0] pos_x_out;
		logic signed [31:0] pos_y_out;
		logic signed [31:0] pos_z_out;
		logic signed [15:0] yaw_out;
		logic signed [15:0] pitch_out;
	} snp_out_t;

	typedef struct packed {
		logic [1:0]        held;
		logic [2:0][31:0]  o_pos;
		logic [2:0][31:0]  n_pos;
		logic [1:0][15:0]  o_ang;
		logic [1:0][15:0]  n_ang;
		logic [39:0]       o_time;
		logic [39:0]       n_time;
		logic [47:0]       render;
	} snp_entry_t;

	function automatic logic [31:0] sat32(input logic signed [57:0] v);
		if (v > 58'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -58'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] sat16(input logic signed [57:0] v);
		if (v > 58'sd32767)
			return 32'h0000_7FFF;
		else if (v < -58'sd32768)
			return 32'hFFFF_8000;
		else
			return {{16{v[15]}}, v[15:0]};
	endfunction

	function automatic logic [31:0] clamp_pitch(input logic signed [57:0] v);
		if (v > 58'(HALF_PI_Q))
			return 32'(HALF_PI_Q);
		else if (v < -58'(HALF_PI_Q))
			return -32'(HALF_PI_Q);
		else
			return v[31:0];
	endfunction

endpackage

// File: src/snp_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface snp_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/snp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module snp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [snp_pkg::DIV_NW-1:0] num,
	input  logic [snp_pkg::DIV_DW-1:0] den,
	output logic                       done,
	output logic [snp_pkg::DIV_NW-1:0] quo
);
	import snp_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] nq_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// The remainder stays below the divisor, so the shifted value fits one extra bit.
	assign shifted = {rem_q, nq_q[DIV_NW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			nq_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				den_q  <= den;
				nq_q   <= num;
				cnt_q  <= CNT_W'(DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
				nq_q  <= {nq_q[DIV_NW-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = nq_q;
endmodule

// File: src/snapshot_interpolation_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_interpolation_table_core
// Per-object table of the two newest pose snapshots with interpolation.
// ----------------------------------------------------------------------------
// One item is worked at a time and yields exactly one result item. A push,
// a remove and an interpolate that holds the newest pose need no division;
// an interpolating or an extrapolating one waits on the shared restoring
// divider: one division for the interpolation fraction, or five divisions
// by the snapshot interval when extrapolating; the yaw wrap adds an
// estimate-and-subtract reduction. Slot state lives in one synchronous
// memory that is read, updated and written back per push or interpolate
// item; slot ids and active flags are flip-flops searched in parallel.
module snapshot_interpolation_table_core #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	snp_chan_if.sink                          in_ch,
	snp_chan_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [snp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [snp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import snp_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_LOOK  = 14'b00000000000010,
		ST_READ  = 14'b00000000000100,
		ST_PREP  = 14'b00000000001000,
		ST_MODE  = 14'b00000000010000,
		ST_TDIV  = 14'b00000000100000,
		ST_MUL   = 14'b00000001000000,
		ST_ADJ   = 14'b00000010000000,
		ST_SDIV  = 14'b00000100000000,
		ST_DIV   = 14'b00001000000000,
		ST_EFIN  = 14'b00010000000000,
		ST_SWRAP = 14'b00100000000000,
		ST_WRAP  = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [19:0] delay_q;
	logic [21:0] cap_q;

	logic [SLOT_COUNT-1:0] active_q;
	logic [7:0]            slot_id_q [SLOT_COUNT];

	snp_in_t       item_q;
	logic [SW-1:0] slot_q;
	logic          new_q;

	snp_entry_t slot_mem [SLOT_COUNT];
	snp_entry_t rd_q;
	snp_entry_t wr_ent;
	logic       mem_re;
	logic       mem_we;

	logic signed [31:0] older_q [5];
	logic signed [31:0] newer_q [5];
	logic signed [32:0] delta_q [5];
	logic signed [40:0] d_q;
	logic signed [47:0] rc_q;
	logic signed [49:0] rcmo_q;
	logic signed [49:0] rcmn_q;
	logic               held2_q;
	logic               extrap_q;
	logic [21:0]        e_q;
	logic [16:0]        t_q;
	logic [2:0]         k_q;
	logic signed [56:0] prod_q;
	logic signed [57:0] acc_q;
	logic [31:0]        res_q [5];
	logic [1:0]         status_q;
	logic [1:0]         mode_q;
	logic [36:0]        wm_q;
	logic [21:0]        wq_q;

	logic     out_valid_q;
	snp_out_t out_q;

	// Slot search.
	logic          hit;
	logic [SW-1:0] hit_idx;
	logic          free;
	logic [SW-1:0] free_idx;

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (active_q[i] && slot_id_q[i] == item_q.object_id) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (!active_q[i]) begin
				free     = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// Entry update for the read-modify-write.
	logic [1:0]  held_old;
	logic [48:0] rc_wide;
	logic [47:0] rc_next;

	assign held_old = new_q ? 2'd0 : rd_q.held;
	assign rc_wide  = {rd_q.render[47], rd_q.render} + {29'd0, item_q.step_us};
	// The clock only moves forward, so the only overflow is past the top.
	assign rc_next  = (rc_wide[48:47] == 2'b01) ? 48'h7FFF_FFFF_FFFF : rc_wide[47:0];

	always_comb begin
		wr_ent = rd_q;
		if (item_q.action == ACT_PUSH) begin
			wr_ent.held = (held_old < 2'd2) ? held_old + 2'd1 : 2'd2;
			if (held_old != 2'd0) begin
				wr_ent.o_pos  = rd_q.n_pos;
				wr_ent.o_ang  = rd_q.n_ang;
				wr_ent.o_time = rd_q.n_time;
			end
			wr_ent.n_pos  = {item_q.pos_z_in, item_q.pos_y_in, item_q.pos_x_in};
			wr_ent.n_ang  = {item_q.pitch_in, item_q.yaw_in};
			wr_ent.n_time = item_q.arrival_time_us;
			if (held_old == 2'd0)
				wr_ent.render = {8'd0, item_q.arrival_time_us} - {28'd0, delay_q};
		end else begin
			wr_ent.render = rc_next;
		end
	end

	assign mem_re = (state_q == ST_LOOK);
	assign mem_we = (state_q == ST_READ) &&
		(item_q.action == ACT_PUSH || item_q.action == ACT_INTERP);

	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem[slot_q] <= wr_ent;
		if (mem_re)
			rd_q <= slot_mem[hit ? hit_idx : free_idx];
	end

	// Mode decision.
	logic        mode_hold;
	logic        mode_interp;
	logic [39:0] num_c;
	logic [21:0] e_c;

	assign mode_hold   = !held2_q || d_q[40] || (d_q == 41'sd0);
	assign mode_interp = (rcmn_q <= 50'sd0);

	always_comb begin
		if (rcmo_q < 50'sd0)
			num_c = '0;
		else if (rcmo_q > 50'(d_q))
			num_c = d_q[39:0];
		else
			num_c = rcmo_q[39:0];
		if (rcmn_q > $signed({28'd0, cap_q}))
			e_c = cap_q;
		else
			e_c = rcmn_q[21:0];
	end

	// Arithmetic helpers.
	logic [22:0]        factor;
	logic [56:0]        prod_mag;
	logic [40:0]        iq;
	logic signed [57:0] iq_s;
	logic signed [57:0] dq_s;
	logic [57:0]        acc_mag;

	logic               div_start;
	logic [DIV_NW-1:0]  div_num;
	logic [DIV_DW-1:0]  div_den;
	logic               div_done;
	logic [DIV_NW-1:0]  div_quo;

	assign factor    = extrap_q ? {1'b0, e_q} : {6'd0, t_q};
	assign prod_mag  = prod_q[56] ? 57'(-prod_q) : 57'(prod_q);
	assign iq        = 41'((prod_mag + 57'd32768) >> 16);
	assign iq_s      = prod_q[56] ? -$signed({17'd0, iq}) : $signed({17'd0, iq});
	assign dq_s      = prod_q[56] ? -$signed({1'b0, div_quo[56:0]})
		: $signed({1'b0, div_quo[56:0]});
	assign acc_mag   = acc_q[57] ? 58'(-acc_q) : 58'(acc_q);

	assign div_start = (state_q == ST_MODE && !mode_hold && mode_interp) ||
		(state_q == ST_SDIV);

	always_comb begin
		priority case (1'b1)
			state_q == ST_SDIV: begin
				div_num = {prod_mag[55:0], 1'b0} + {17'd0, d_q};
				div_den = {d_q, 1'b0};
			end
			default: begin
				div_num = {2'd0, num_c, 16'd0};
				div_den = {1'b0, d_q};
			end
		endcase
	end

	snp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Yaw wrap of the extrapolated angle: the magnitude is reduced modulo 2*pi
	// by a quotient estimate from its high bits, then by single subtractions.
	// 83442 lies just below 2^32 / 51472, so the estimate never overshoots.
	logic [37:0]        wrap_est;
	logic [37:0]        wrap_sub;
	logic signed [16:0] wrap_mag;
	logic signed [16:0] wrap_val;

	assign wrap_est = {17'd0, wm_q[36:16]} * 38'd83442;
	assign wrap_sub = {16'd0, wq_q} * 38'(TWO_PI_Q);
	assign wrap_mag = (wm_q >= 37'(HALF_WRAP))
		? $signed({1'b0, wm_q[15:0]}) - 17'(TWO_PI_Q)
		: $signed({1'b0, wm_q[15:0]});
	assign wrap_val = acc_q[57] ? -wrap_mag : wrap_mag;

	// Yaw delta wrapped the short way round.
	logic signed [16:0] dyaw_raw;
	logic signed [16:0] dyaw;

	assign dyaw_raw = $signed({rd_q.n_ang[0][15], rd_q.n_ang[0]}) -
		$signed({rd_q.o_ang[0][15], rd_q.o_ang[0]});

	always_comb begin
		if (dyaw_raw >= 17'sd25736)
			dyaw = dyaw_raw - 17'sd51472;
		else if (dyaw_raw <= -17'sd25736)
			dyaw = dyaw_raw + 17'sd51472;
		else
			dyaw = dyaw_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			delay_q     <= RENDER_DELAY_RST;
			cap_q       <= EXTRAP_CAP_RST;
			active_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			item_q      <= '0;
			slot_q      <= '0;
			new_q       <= 1'b0;
			d_q         <= '0;
			rc_q        <= '0;
			rcmo_q      <= '0;
			rcmn_q      <= '0;
			held2_q     <= 1'b0;
			extrap_q    <= 1'b0;
			e_q         <= '0;
			t_q         <= '0;
			k_q         <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			wm_q        <= '0;
			wq_q        <= '0;
			status_q    <= STAT_OK;
			mode_q      <= MODE_HOLD;
			for (int i = 0; i < SLOT_COUNT; i++)
				slot_id_q[i] <= '0;
			for (int i = 0; i < 5; i++) begin
				older_q[i] <= '0;
				newer_q[i] <= '0;
				delta_q[i] <= '0;
				res_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_RENDER_DELAY)
					delay_q <= cfg_data[19:0];
				else
					cap_q <= cfg_data[21:0];
			end

			if (out_valid_q && out_ch.ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						item_q  <= in_ch.data;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					mode_q <= MODE_HOLD;
					for (int i = 0; i < 5; i++)
						res_q[i] <= '0;
					slot_q <= hit ? hit_idx : free_idx;
					new_q  <= !hit;
					if (item_q.action == ACT_PUSH && (hit || free)) begin
						status_q <= STAT_OK;
						state_q  <= ST_READ;
					end else if (item_q.action == ACT_PUSH) begin
						status_q <= STAT_NO_SLOT;
						state_q  <= ST_DONE;
					end else if (item_q.action == ACT_INTERP && hit) begin
						status_q <= STAT_OK;
						state_q  <= ST_READ;
					end else if ((item_q.action == ACT_INTERP ||
						item_q.action == ACT_REMOVE) && !hit) begin
						status_q <= STAT_NOT_FOUND;
						state_q  <= ST_DONE;
					end else begin
						status_q <= STAT_OK;
						state_q  <= ST_DONE;
						if (item_q.action == ACT_REMOVE)
							active_q[hit_idx] <= 1'b0;
					end
				end
				ST_READ: begin
					rc_q <= $signed(rc_next);
					if (item_q.action == ACT_PUSH) begin
						if (new_q) begin
							active_q[slot_q]  <= 1'b1;
							slot_id_q[slot_q] <= item_q.object_id;
						end
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					for (int i = 0; i < 3; i++) begin
						older_q[i] <= $signed(rd_q.o_pos[i]);
						newer_q[i] <= $signed(rd_q.n_pos[i]);
						delta_q[i] <= $signed({rd_q.n_pos[i][31], rd_q.n_pos[i]}) -
							$signed({rd_q.o_pos[i][31], rd_q.o_pos[i]});
					end
					for (int i = 0; i < 2; i++) begin
						older_q[3+i] <= $signed({{16{rd_q.o_ang[i][15]}}, rd_q.o_ang[i]});
						newer_q[3+i] <= $signed({{16{rd_q.n_ang[i][15]}}, rd_q.n_ang[i]});
					end
					delta_q[3] <= $signed({{16{dyaw[16]}}, dyaw});
					delta_q[4] <= $signed({{16{1'b0}}, 17'd0}) +
						($signed({{17{rd_q.n_ang[1][15]}}, rd_q.n_ang[1]}) -
						$signed({{17{rd_q.o_ang[1][15]}}, rd_q.o_ang[1]}));
					d_q     <= $signed({1'b0, rd_q.n_time}) - $signed({1'b0, rd_q.o_time});
					rcmo_q  <= $signed({{2{rc_q[47]}}, rc_q}) - $signed({10'd0, rd_q.o_time});
					rcmn_q  <= $signed({{2{rc_q[47]}}, rc_q}) - $signed({10'd0, rd_q.n_time});
					held2_q <= (rd_q.held == 2'd2);
					state_q <= ST_MODE;
				end
				ST_MODE: begin
					k_q <= '0;
					if (mode_hold) begin
						for (int i = 0; i < 5; i++)
							res_q[i] <= newer_q[i];
						mode_q  <= MODE_HOLD;
						state_q <= ST_DONE;
					end else if (mode_interp) begin
						extrap_q <= 1'b0;
						mode_q   <= MODE_INTERP;
						state_q  <= ST_TDIV;
					end else begin
						extrap_q <= 1'b1;
						e_q      <= e_c;
						mode_q   <= MODE_EXTRAP;
						state_q  <= ST_MUL;
					end
				end
				ST_TDIV: begin
					if (div_done) begin
						t_q     <= div_quo[16:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= 57'(delta_q[k_q] * $signed({1'b0, factor}));
					state_q <= extrap_q ? ST_SDIV : ST_ADJ;
				end
				ST_ADJ: begin
					if (k_q < 3'd3)
						res_q[k_q] <= sat32($signed({{26{older_q[k_q][31]}}, older_q[k_q]}) + iq_s);
					else
						res_q[k_q] <= sat16($signed({{26{older_q[k_q][31]}}, older_q[k_q]}) + iq_s);
					k_q     <= k_q + 3'd1;
					state_q <= (k_q == 3'd4) ? ST_DONE : ST_MUL;
				end
				ST_SDIV: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						acc_q   <= $signed({{26{newer_q[k_q][31]}}, newer_q[k_q]}) + dq_s;
						state_q <= ST_EFIN;
					end
				end
				ST_EFIN: begin
					if (k_q == 3'd3) begin
						wm_q    <= acc_mag[36:0];
						state_q <= ST_SWRAP;
					end else begin
						if (k_q < 3'd3)
							res_q[k_q] <= sat32(acc_q);
						else
							res_q[k_q] <= clamp_pitch(acc_q);
						k_q     <= k_q + 3'd1;
						state_q <= (k_q == 3'd4) ? ST_DONE : ST_MUL;
					end
				end
				ST_SWRAP: begin
					if (wm_q[36:18] != '0) begin
						wq_q    <= wrap_est[37:16];
						state_q <= ST_WRAP;
					end else if (wm_q >= 37'(TWO_PI_Q)) begin
						wm_q <= wm_q - 37'(TWO_PI_Q);
					end else begin
						// The wrapped yaw fits 16 bits.
						res_q[3] <= {16'd0, wrap_val[15:0]};
						k_q      <= k_q + 3'd1;
						state_q  <= ST_MUL;
					end
				end
				ST_WRAP: begin
					wm_q    <= wm_q - wrap_sub[36:0];
					state_q <= ST_SWRAP;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q     <= 1'b1;
						out_q.status    <= status_q;
						out_q.pose_mode <= mode_q;
						out_q.pos_x_out <= res_q[0];
						out_q.pos_y_out <= res_q[1];
						out_q.pos_z_out <= res_q[2];
						out_q.yaw_out   <= res_q[3][15:0];
						out_q.pitch_out <= res_q[4][15:0];
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

// File: src/snp_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_check
// Port-level checks of the snapshot table, bound to the top level.
// ----------------------------------------------------------------------------
module snp_check (
	input logic        clk,
	input logic        arst_n,
	snp_chan_if.sink   in_ch,
	snp_chan_if.source out_ch
);
	import snp_pkg::*;

	// A result waiting for its sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
		else $error("stalled result item changed");

	// Items are worked one at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("second item accepted while one is in work");

	a_err_no_pose: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.status != STAT_OK |->
		out_ch.data.pose_mode == MODE_HOLD && out_ch.data.pos_x_out == 32'sd0 &&
		out_ch.data.yaw_out == 16'sd0)
		else $error("error result carries a pose");

	a_pitch_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.pose_mode == MODE_EXTRAP |->
		out_ch.data.pitch_out <= 16'sd12868 && out_ch.data.pitch_out >= -16'sd12868)
		else $error("extrapolated pitch outside the clamp");
endmodule

bind snapshot_interpolation_table_core snp_check u_snp_check (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch)
);
